// ----- src/msrs_pkg.sv -----
// ----------------------------------------------------------------------------
// msrs_pkg: shared types and constants of the message slot ring status unit
// Slot status codes, request kinds, result codes, the memory access structs
// and the position mask helper.
// ----------------------------------------------------------------------------
`default_nettype none

package msrs_pkg;

    localparam int LOG2_SLOTS = 6;
    localparam int DEPTH      = 1 << LOG2_SLOTS;
    localparam int SLOT_W     = LOG2_SLOTS;
    localparam int CFG_W      = 3;

    localparam logic [CFG_W-1:0] RING_LOG2_RST = CFG_W'(LOG2_SLOTS);

    // Result codes carried in the result word's tuser
    localparam logic RC_OK    = 1'b0;
    localparam logic RC_BLOCK = 1'b1;

    typedef enum logic [1:0] {
        ST_AVAIL = 2'd0,
        ST_BUSY  = 2'd1,
        ST_SENT  = 2'd2
    } t_status_e;

    typedef enum logic [1:0] {
        REQ_SEND_START = 2'd0,
        REQ_SEND_END   = 2'd1,
        REQ_RECV_START = 2'd2,
        REQ_RECV_END   = 2'd3
    } t_req_e;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_status_e         data;
    } t_wr_req;

    // Mask of the ring in use; the size code saturates at log2 of the slot count.
    function automatic logic [SLOT_W-1:0] pos_mask(input logic [CFG_W-1:0] ring_log2);
        logic [CFG_W-1:0] k;
        logic [SLOT_W:0]  full;
        k = (ring_log2 > CFG_W'(LOG2_SLOTS)) ? CFG_W'(LOG2_SLOTS) : ring_log2;
        full = ((SLOT_W+1)'(1) << k) - (SLOT_W+1)'(1);
        return full[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/message_slot_ring_status_unit.sv -----
// ----------------------------------------------------------------------------
// message_slot_ring_status_unit: status tracker of a message slot ring
// Single-producer, single-consumer ring of slots with available, busy and
// sent status, producer and consumer positions and a configurable size.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as words on the s_ channel: tuser carries the request
//   kind (send start, send end, receive start, receive end), tdata the slot
//   that an end request finishes. Each request yields exactly one result
//   word on the m_ channel: tuser bit 0 is the would-block flag, tdata the
//   slot claimed by a successful start request (zero otherwise).
//   A request reads its slot status into the store's read register when it
//   is accepted, and is written back when it resolves, at the edge where
//   its result word turns valid; a waiting result word holds the resolve
//   back. The next request is taken only once the write-back is done.
//   Reset: all slots read as available (per-slot valid bits cleared at once),
//   both positions return to zero and the ring size code to six. No
//   clearing pass is needed.
//   Stall: the result register parts the two sides. A request is accepted
//   while a result waits; it then holds in the resolve stage until the
//   result register is free.
//   The user writes the ring size register (i_cfg_we / i_cfg_wdata) only
//   while no request is in flight; the block leaves this to the user.
// ----------------------------------------------------------------------------
`default_nettype none

module message_slot_ring_status_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // configuration: ring_size_log2
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_wdata,
    // request channel
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire [7:0]  i_s_tdata,   // [5:0] target_slot, [7:6] zero
    input  wire [1:0]  i_s_tuser,   // [1:0] req_type
    // result channel
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata,   // [5:0] claimed_slot, [7:6] zero
    output logic [0:0] o_m_tuser    // [0] result_code
);

    localparam int SW = msrs_pkg::SLOT_W;

    // configuration
    logic [msrs_pkg::CFG_W-1:0] r_ring_log2;
    logic [SW-1:0]              w_mask;

    // positions
    logic [SW-1:0] r_prod, n_prod;
    logic [SW-1:0] r_cons, n_cons;

    // request in flight
    logic             r_busy, n_busy;
    msrs_pkg::t_req_e r_req;
    logic [SW-1:0]    r_addr;

    // result register
    logic          r_ovalid, n_ovalid;
    logic          r_ocode,  n_ocode;
    logic [SW-1:0] r_oslot,  n_oslot;

    logic                w_accept;
    logic                w_exec;
    msrs_pkg::t_req_e    w_in_req;
    logic [SW-1:0]       w_in_addr;
    msrs_pkg::t_status_e w_status;
    msrs_pkg::t_rd_req   w_rd;
    msrs_pkg::t_wr_req   w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_log2 <= msrs_pkg::RING_LOG2_RST;
        end else if (i_cfg_we) begin
            r_ring_log2 <= i_cfg_wdata;
        end
    end

    assign w_mask = msrs_pkg::pos_mask(r_ring_log2);

    // Take a request only when the previous one has been written back.
    assign o_s_tready = !r_busy;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_in_req   = msrs_pkg::t_req_e'(i_s_tuser);

    // Slot address: start requests use their position, end requests the target.
    always_comb begin
        unique case (w_in_req)
            msrs_pkg::REQ_SEND_START: w_in_addr = r_prod & w_mask;
            msrs_pkg::REQ_RECV_START: w_in_addr = r_cons & w_mask;
            default:                  w_in_addr = i_s_tdata[SW-1:0] & w_mask;
        endcase
    end

    assign w_rd.en   = w_accept;
    assign w_rd.addr = w_in_addr;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= w_in_req;
            r_addr <= w_in_addr;
        end
    end

    msrs_status_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (w_rd),
        .i_wr     (w_wr),
        .o_status (w_status)
    );

    // Resolve when the result register is free or drains this cycle.
    assign w_exec = r_busy && (!r_ovalid || i_m_tready);

    always_comb begin
        n_prod      = r_prod;
        n_cons      = r_cons;
        n_busy      = r_busy;
        n_ovalid    = r_ovalid;
        n_ocode     = r_ocode;
        n_oslot     = r_oslot;
        w_wr.en     = 1'b0;
        w_wr.addr   = r_addr;
        w_wr.data   = msrs_pkg::ST_BUSY;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end
        if (w_accept) begin
            n_busy = 1'b1;
        end

        if (w_exec) begin
            n_busy   = 1'b0;
            n_ovalid = 1'b1;
            n_ocode  = msrs_pkg::RC_OK;
            n_oslot  = '0;
            unique case (r_req)
                msrs_pkg::REQ_SEND_START: begin
                    if (w_status == msrs_pkg::ST_AVAIL) begin
                        w_wr.en = 1'b1;
                        n_prod  = r_prod + SW'(1);
                        n_oslot = r_addr;
                    end else begin
                        n_ocode = msrs_pkg::RC_BLOCK;
                    end
                end
                msrs_pkg::REQ_RECV_START: begin
                    if (w_status == msrs_pkg::ST_SENT) begin
                        w_wr.en = 1'b1;
                        n_cons  = r_cons + SW'(1);
                        n_oslot = r_addr;
                    end else begin
                        n_ocode = msrs_pkg::RC_BLOCK;
                    end
                end
                msrs_pkg::REQ_SEND_END: begin
                    w_wr.en   = 1'b1;
                    w_wr.data = msrs_pkg::ST_SENT;
                end
                default: begin
                    w_wr.en   = 1'b1;
                    w_wr.data = msrs_pkg::ST_AVAIL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod   <= '0;
            r_cons   <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_prod   <= n_prod;
            r_cons   <= n_cons;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ocode <= n_ocode;
        r_oslot <= n_oslot;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(8-SW){1'b0}}, r_oslot};
    assign o_m_tuser  = r_ocode;

    // ---- assertions --------------------------------------------------------

    // An accepted request blocks the input until it is written back.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in flight");

    // A successful send start advances the producer position by one.
    a_prod_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && (r_req == msrs_pkg::REQ_SEND_START)
            && (w_status == msrs_pkg::ST_AVAIL))
        |=> (r_prod == $past(r_prod + SW'(1))))
        else $error("producer position did not advance on a claim");

    // Positions only move on a resolve.
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_exec |=> ($stable(r_prod) && $stable(r_cons)))
        else $error("position moved without a resolved request");

    // A would-block result carries slot zero.
    a_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[0] == msrs_pkg::RC_BLOCK)) |-> (o_m_tdata == 8'd0))
        else $error("would-block result with a nonzero slot");

endmodule

`default_nettype wire

// ----- src/msrs_status_store.sv -----
// ----------------------------------------------------------------------------
// msrs_status_store: slot status memory
// One-port-read, one-port-write status array with a registered read and
// per-slot valid bits that make every slot read as available after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module msrs_status_store (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  msrs_pkg::t_rd_req    i_rd,
    input  msrs_pkg::t_wr_req    i_wr,
    output msrs_pkg::t_status_e  o_status
);

    msrs_pkg::t_status_e             r_mem [msrs_pkg::DEPTH];
    msrs_pkg::t_status_e             r_rdata;
    logic [msrs_pkg::SLOT_W-1:0]     r_rd_addr;
    logic [msrs_pkg::DEPTH-1:0]      r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata   <= r_mem[i_rd.addr];
            r_rd_addr <= i_rd.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Unwritten slots read as available.
    assign o_status = r_valid[r_rd_addr] ? r_rdata : msrs_pkg::ST_AVAIL;

endmodule

`default_nettype wire

// ----- tb/tb_message_slot_ring_status_unit.sv -----
// ----------------------------------------------------------------------------
// tb_message_slot_ring_status_unit: self-checking bench of the slot ring unit
// Drives request words on the s_ stream and scores every result word on the
// m_ stream against a cycle-free predictor of the ring: slot status, producer
// and consumer positions and the ring size register. A short scripted part
// hits the corner cases; random phases then run producer/consumer flows at
// several ring sizes, with bursty stalls on both sides and one long
// back-pressure hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_message_slot_ring_status_unit;

    localparam int SW = msrs_pkg::SLOT_W;
    localparam int CW = msrs_pkg::CFG_W;

    // Cycles with no word moving on either side before the run is declared hung
    localparam int STALL_LIMIT = 3000;
    // Length of the long back-pressure hold on the result side
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic          code;    // would-block flag
        logic [SW-1:0] slot;    // claimed slot
    } t_ring_result;

    // One line of the scripted part: either a ring size write or a request,
    // with an optional typed-in result that replaces the prediction
    typedef struct {
        bit               is_cfg;
        logic [CW-1:0]    ring_val;
        msrs_pkg::t_req_e req;
        logic [SW-1:0]    tgt;
        bit               typed;
        t_ring_result     want;
    } t_script_row;

    localparam t_ring_result OK_NONE = '{msrs_pkg::RC_OK, 6'd0};
    localparam t_ring_result BLOCKED = '{msrs_pkg::RC_BLOCK, 6'd0};

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_cfg_we    = 1'b0;
    logic [CW-1:0] i_cfg_wdata = '0;
    logic          i_s_tvalid  = 1'b0;
    logic          o_s_tready;
    logic [7:0]    i_s_tdata   = '0;     // [5:0] target_slot, [7:6] zero
    logic [1:0]    i_s_tuser   = '0;     // [1:0] req_type
    logic          o_m_tvalid;
    logic          i_m_tready  = 1'b0;
    logic [7:0]    o_m_tdata;            // [5:0] claimed_slot, [7:6] zero
    logic [0:0]    o_m_tuser;            // [0] result_code

    // Predictor state: a private copy of the ring
    msrs_pkg::t_status_e slot_state [msrs_pkg::DEPTH];
    logic [SW-1:0]       prod_pos;
    logic [SW-1:0]       cons_pos;
    logic [CW-1:0]       ring_log2_q;

    // Results still owed by the block, oldest first
    t_ring_result  pending_results [$];
    // Slots held by the producer (claimed, not yet sent) and by the consumer
    logic [SW-1:0] prod_held [$];
    logic [SW-1:0] cons_held [$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    bit idle_on       = 1'b1;   // allow random idle bursts on both sides
    bit long_hold_req = 1'b0;   // ask the result side for one long hold-off

    message_slot_ring_status_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Mask of the ring in use; size codes above log2 of the slot count saturate
    function automatic logic [SW-1:0] ring_mask(input logic [CW-1:0] log2);
        int k;
        k = (log2 > msrs_pkg::LOG2_SLOTS) ? msrs_pkg::LOG2_SLOTS : int'(log2);
        return SW'((1 << k) - 1);
    endfunction

    // Apply one request to the predicted ring and return its result
    task automatic resolve_request(input msrs_pkg::t_req_e req, input logic [SW-1:0] tgt,
                                   output t_ring_result res);
        logic [SW-1:0] m;
        logic [SW-1:0] idx;
        m   = ring_mask(ring_log2_q);
        res = OK_NONE;
        case (req)
            msrs_pkg::REQ_SEND_START: begin
                idx = prod_pos & m;
                if (slot_state[idx] == msrs_pkg::ST_AVAIL) begin
                    slot_state[idx] = msrs_pkg::ST_BUSY;
                    prod_pos        = prod_pos + 1'b1;
                    res.slot        = idx;
                end else begin
                    res = BLOCKED;
                end
            end
            msrs_pkg::REQ_RECV_START: begin
                idx = cons_pos & m;
                if (slot_state[idx] == msrs_pkg::ST_SENT) begin
                    slot_state[idx] = msrs_pkg::ST_BUSY;
                    cons_pos        = cons_pos + 1'b1;
                    res.slot        = idx;
                end else begin
                    res = BLOCKED;
                end
            end
            // End requests write unconditionally into the wrapped target
            msrs_pkg::REQ_SEND_END: slot_state[tgt & m] = msrs_pkg::ST_SENT;
            default:                slot_state[tgt & m] = msrs_pkg::ST_AVAIL;
        endcase
    endtask

    // Offer one request word, hold it until taken, then log what it owes
    task automatic issue_request(input msrs_pkg::t_req_e req, input logic [SW-1:0] tgt,
                                 input bit typed, input t_ring_result want,
                                 output t_ring_result res);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {2'b00, tgt};
        do @(posedge i_clk); while (!o_s_tready);
        resolve_request(req, tgt, res);
        pending_results.push_back(typed ? want : res);
    endtask

    // Drain the block, settle, then write the ring size register
    task automatic write_ring_size(input logic [CW-1:0] val);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ring_log2_q  = val;
        // Drop held slots: after a re-mask they no longer line up
        prod_held.delete();
        cons_held.delete();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, scripted corner cases, then random phases
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_script_row      script [$];
        t_ring_result     res;
        msrs_pkg::t_req_e req;
        logic [SW-1:0]    tgt;
        logic [SW-1:0]    m;
        int               p;
        int               n;
        int               i;

        // After reset: ring of 64, everything available
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_START, 6'd0,  1, BLOCKED});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_START, 6'd0,  1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_START, 6'd0,  1,
                           '{msrs_pkg::RC_OK, 6'd1}});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_END,   6'd0,  1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_START, 6'd0,  1, OK_NONE});
        // Consumer reaches a slot that is still busy
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_START, 6'd0,  1, BLOCKED});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_END,   6'd0,  1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_END,   6'd63, 1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_END,   6'd63, 1, OK_NONE});
        // Single-slot ring: positions re-mask to slot zero, targets wrap
        script.push_back('{1, 3'd0, msrs_pkg::REQ_SEND_START, 6'd0,  0, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_START, 6'd0,  1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_START, 6'd0,  1, BLOCKED});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_END,   6'd63, 1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_START, 6'd0,  1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_END,   6'd42, 1, OK_NONE});
        // Size code above log2 of the slot count saturates to the full ring
        script.push_back('{1, 3'd7, msrs_pkg::REQ_SEND_START, 6'd0,  0, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_START, 6'd0,  0, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_END,   6'd63, 1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_END,   6'd1,  1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_START, 6'd0,  0, OK_NONE});
        // Eight-slot ring with a target beyond it
        script.push_back('{1, 3'd3, msrs_pkg::REQ_SEND_START, 6'd0,  0, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_START, 6'd0,  0, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_SEND_END,   6'd60, 1, OK_NONE});
        script.push_back('{0, 3'd0, msrs_pkg::REQ_RECV_START, 6'd0,  0, OK_NONE});
        script.push_back('{1, 3'd6, msrs_pkg::REQ_SEND_START, 6'd0,  0, OK_NONE});

        for (i = 0; i < msrs_pkg::DEPTH; i++) slot_state[i] = msrs_pkg::ST_AVAIL;
        prod_pos    = '0;
        cons_pos    = '0;
        ring_log2_q = msrs_pkg::RING_LOG2_RST;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].is_cfg) begin
                write_ring_size(script[r].ring_val);
            end else begin
                issue_request(script[r].req, script[r].tgt, script[r].typed,
                              script[r].want, res);
            end
        end

        for (p = 0; p < 11; p++) begin
            // Hit both size extremes every other phase, random sizes between
            write_ring_size((p % 4 == 1) ? 3'd0 :
                            (p % 4 == 3) ? 3'd7 : CW'($urandom_range(0, 7)));
            // Run the last phases with no idling on either side
            if (p == 9) idle_on = 1'b0;
            // Starve the result side so the block backs up into its input
            if (p == 3) long_hold_req = 1'b1;
            for (n = 0; n < 50; n++) begin
                // Pause the producer side once until the block runs dry
                if (p == 5 && n == 25) begin
                    i_s_tvalid <= 1'b0;
                    do @(posedge i_clk); while (pending_results.size() != 0);
                end
                m = ring_mask(ring_log2_q);
                if ($urandom_range(0, 99) < 15) begin
                    // Noise: any request, any target
                    req = msrs_pkg::t_req_e'($urandom_range(0, 3));
                    tgt = SW'($urandom);
                end else if (prod_held.size() != 0 && $urandom_range(0, 1) == 1) begin
                    // Finish a held send; junk above the mask must wrap away
                    req = msrs_pkg::REQ_SEND_END;
                    tgt = prod_held.pop_front() | (SW'($urandom) & ~m);
                end else if (cons_held.size() != 0 && $urandom_range(0, 1) == 1) begin
                    req = msrs_pkg::REQ_RECV_END;
                    tgt = cons_held.pop_front() | (SW'($urandom) & ~m);
                end else begin
                    req = ($urandom_range(0, 1) == 1) ? msrs_pkg::REQ_SEND_START
                                                      : msrs_pkg::REQ_RECV_START;
                    tgt = SW'($urandom);
                end
                issue_request(req, tgt, 1'b0, OK_NONE, res);
                // Track claimed slots so the flow can finish them later
                if (res.code == msrs_pkg::RC_OK && req == msrs_pkg::REQ_SEND_START) begin
                    prod_held.push_back(res.slot);
                end
                if (res.code == msrs_pkg::RC_OK && req == msrs_pkg::REQ_RECV_START) begin
                    cons_held.push_back(res.slot);
                end
            end
        end

        // Drain, let the pipeline settle, then report
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side ready: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_tready   <= 1'b0;
                for (hold = 0; hold < LONG_HOLD; hold++) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Score each result word against the oldest expectation; watch for hangs
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_ring_result want;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result word: result_code %0d claimed_slot %0d",
                                 o_m_tuser[0], o_m_tdata[5:0]);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tuser[0] !== want.code || o_m_tdata[5:0] !== want.slot) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: code exp %0d got %0d, slot exp %0d got %0d",
                                     want.code, o_m_tuser[0], want.slot, o_m_tdata[5:0]);
                        end
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
